### sv/esp_pkg.sv
package esp_pkg;

    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 20;
    localparam int STEP_W     = 5;

    localparam logic [31:0] SPEED_NUM     = 32'd37500000;
    localparam logic [31:0] DERIV_NUM     = 32'd2861022949;
    localparam logic [15:0] HALF_CAP      = 16'd32000;
    localparam logic [12:0] RPM_CAP       = 13'd7500;
    localparam logic [12:0] FILT_NONE     = 13'd8191;
    localparam logic [15:0] ACCEL_MIN_PER = 16'd171;
    localparam logic [15:0] SPEED_SAT     = 16'd65535;
    localparam logic [15:0] DERIV_POS_CAP = 16'd127;
    localparam logic [15:0] DERIV_NEG_CAP = 16'd128;
    localparam logic [3:0]  CYL_RESET     = 4'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DP,
        S_SPEED,
        S_FILT,
        S_Q,
        S_CUR,
        S_PRV,
        S_Q2,
        S_CUR2,
        S_PRV2,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

    // Difference a - b, limited to +pos_cap and -neg_cap, as a 17-bit signed value.
    function automatic logic signed [16:0] clamp_diff(
        input logic [31:0] a,
        input logic [31:0] b,
        input logic [15:0] pos_cap,
        input logic [15:0] neg_cap
    );
        logic [31:0] d;
        logic [15:0] m;
        begin
            if (a >= b) begin
                d = a - b;
                m = (d > {16'd0, pos_cap}) ? pos_cap : d[15:0];
                clamp_diff = signed'({1'b0, m});
            end
            else begin
                d = b - a;
                m = (d > {16'd0, neg_cap}) ? neg_cap : d[15:0];
                clamp_diff = -signed'({1'b0, m});
            end
        end
    endfunction

endpackage

### sv/esp_divider.sv
module esp_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  esp_pkg::div_req_t req,
    output esp_pkg::div_rsp_t rsp
);
    import esp_pkg::*;

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W:0]    rem_reg;
    logic [STEP_W-1:0]     cnt_reg;
    logic [DIVISOR_W-1:0]  dvs_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    assign trial = {rem_reg[DIVISOR_W-1:0], quo_reg[DIVIDEND_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(DIVIDEND_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk) begin
        if (req.start) begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg) begin
            rem_reg <= fits ? (trial - {1'b0, dvs_reg}) : trial;
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

### sv/engine_speed_from_tdc_period.sv
// Engine speed from the top-dead-centre period. One request carries one period and gives one
// result with speed in eighths of rpm, derived forms, a moving average over as many events as
// there are cylinders (at most four are summed), and two speed-change values. All nine
// divisions run one after another on a single shared divider that resolves one quotient bit
// per clock. Each division has a launch, 32 quotient steps and a step that hands back the
// quotient. in_stall stays high from acceptance until the result is loaded into the output
// register, so the block takes no new request before it is through with the last one. A
// finished result waits in the output register while the next request is taken.
module engine_speed_from_tdc_period
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [3:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] tdc_period,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] speed_eighth_rpm,
    output logic [14:0] speed_half_res,
    output logic [12:0] speed_rpm,
    output logic [7:0]  speed_coarse,
    output logic [12:0] speed_capped,
    output logic [12:0] speed_filtered,
    output logic signed [7:0]  speed_derivative,
    output logic signed [15:0] engine_accel,
    output logic        count_error
);
    import esp_pkg::*;

    seq_state_t  state_reg, state_next;
    logic        launch_reg;
    logic [3:0]  cyl_reg;
    logic [15:0] p_reg, pp_reg;
    logic [3:0]  n_reg;
    logic [12:0] hist_reg [0:2];
    logic [31:0] dp_reg, q_reg, cur_reg;
    logic [15:0] speed_reg;
    logic [12:0] filt_reg;
    logic [7:0]  deriv_reg;
    logic [15:0] accel_reg;
    logic        out_valid_reg;
    logic [15:0] o_speed_reg;
    logic [14:0] o_half_reg;
    logic [12:0] o_rpm_reg, o_capped_reg, o_filt_reg;
    logic [7:0]  o_coarse_reg, o_deriv_reg;
    logic [15:0] o_accel_reg;
    logic        o_err_reg;

    div_req_t    div_req;
    div_rsp_t    div_rsp;
    logic        accept, load_out;
    logic [19:0] pn, p_div, pp_div, n_div, pn_div;
    logic [12:0] rpm;
    logic [14:0] sum;
    logic [15:0] half;
    logic signed [16:0] dd;

    assign accept = in_valid && !in_stall;
    assign in_stall = state_reg != S_IDLE;
    assign load_out = state_reg == S_DONE && (!out_valid_reg || !out_stall);

    assign pn     = 20'(p_reg) * 20'(n_reg);
    assign p_div  = (p_reg == 16'd0) ? 20'd1 : 20'(p_reg);
    assign pp_div = (pp_reg == 16'd0) ? 20'd1 : 20'(pp_reg);
    assign n_div  = (n_reg == 4'd0) ? 20'd1 : 20'(n_reg);
    assign pn_div = (pn == 20'd0) ? 20'd1 : pn;
    assign rpm    = speed_reg[15:3];

    always_comb begin
        case (n_reg)
            4'd1:    sum = 15'(rpm);
            4'd2:    sum = 15'(rpm) + 15'(hist_reg[0]);
            4'd3:    sum = 15'(rpm) + 15'(hist_reg[0]) + 15'(hist_reg[1]);
            default: sum = 15'(rpm) + 15'(hist_reg[0]) + 15'(hist_reg[1]) + 15'(hist_reg[2]);
        endcase
    end

    always_comb begin
        div_req.start    = launch_reg;
        div_req.dividend = q_reg;
        div_req.divisor  = p_div;
        case (state_reg)
            S_DP:
            begin
                div_req.dividend = DERIV_NUM;
                div_req.divisor  = p_div;
            end
            S_SPEED:
            begin
                div_req.dividend = SPEED_NUM;
                div_req.divisor  = pn_div;
            end
            S_FILT:
            begin
                div_req.dividend = 32'(sum);
                div_req.divisor  = n_div;
            end
            S_Q:
            begin
                div_req.dividend = dp_reg;
                div_req.divisor  = n_div;
            end
            S_Q2:
            begin
                div_req.dividend = {dp_reg[23:0], 8'd0};
                div_req.divisor  = n_div;
            end
            S_PRV, S_PRV2:
            begin
                div_req.dividend = q_reg;
                div_req.divisor  = pp_div;
            end
            default:
            begin
                div_req.dividend = q_reg;
                div_req.divisor  = p_div;
            end
        endcase
    end

    esp_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_DP;
            S_DP:    if (div_rsp.done) state_next = S_SPEED;
            S_SPEED: if (div_rsp.done) state_next = S_FILT;
            S_FILT:  if (div_rsp.done) state_next = S_Q;
            S_Q:     if (div_rsp.done) state_next = S_CUR;
            S_CUR:   if (div_rsp.done) state_next = S_PRV;
            S_PRV:   if (div_rsp.done) state_next = S_Q2;
            S_Q2:    if (div_rsp.done) state_next = S_CUR2;
            S_CUR2:  if (div_rsp.done) state_next = S_PRV2;
            S_PRV2:  if (div_rsp.done) state_next = S_DONE;
            S_DONE:  if (load_out) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            launch_reg    <= 1'b0;
            cyl_reg       <= CYL_RESET;
            out_valid_reg <= 1'b0;
            pp_reg        <= '0;
            hist_reg[0]   <= '0;
            hist_reg[1]   <= '0;
            hist_reg[2]   <= '0;
        end
        else begin
            state_reg  <= state_next;
            launch_reg <= state_next != state_reg && state_next != S_IDLE
                          && state_next != S_DONE;
            if (cfg_write) begin
                cyl_reg <= cfg_data;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
                pp_reg        <= p_reg;
                hist_reg[0]   <= rpm;
                hist_reg[1]   <= hist_reg[0];
                hist_reg[2]   <= hist_reg[1];
            end
            else if (!out_stall) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign dd = clamp_diff(cur_reg, div_rsp.quotient,
                           (state_reg == S_PRV) ? DERIV_POS_CAP : HALF_CAP,
                           (state_reg == S_PRV) ? DERIV_NEG_CAP : HALF_CAP);
    assign half = (speed_reg[15:1] > HALF_CAP[14:0]) ? HALF_CAP : {1'b0, speed_reg[15:1]};

    always_ff @(posedge clk) begin
        if (accept) begin
            p_reg <= tdc_period;
            n_reg <= cyl_reg;
        end
        if (div_rsp.done) begin
            case (state_reg)
                S_DP:    dp_reg <= div_rsp.quotient;
                S_SPEED:
                begin
                    if (p_reg == 16'd0 || n_reg == 4'd0) begin
                        speed_reg <= '0;
                    end
                    else if (div_rsp.quotient > {16'd0, SPEED_SAT}) begin
                        speed_reg <= SPEED_SAT;
                    end
                    else begin
                        speed_reg <= div_rsp.quotient[15:0];
                    end
                end
                S_FILT:  filt_reg <= (n_reg == 4'd0) ? FILT_NONE : div_rsp.quotient[12:0];
                S_Q, S_Q2: q_reg <= div_rsp.quotient;
                S_CUR, S_CUR2: cur_reg <= div_rsp.quotient;
                S_PRV:
                begin
                    if (n_reg == 4'd0) begin
                        deriv_reg <= 8'd0;
                    end
                    else if (p_reg == 16'd0) begin
                        deriv_reg <= DERIV_POS_CAP[7:0];
                    end
                    else if (pp_reg == 16'd0) begin
                        deriv_reg <= DERIV_NEG_CAP[7:0];
                    end
                    else begin
                        deriv_reg <= dd[7:0];
                    end
                end
                S_PRV2:
                begin
                    if (n_reg == 4'd0) begin
                        accel_reg <= 16'd0;
                    end
                    else if (p_reg < ACCEL_MIN_PER) begin
                        accel_reg <= HALF_CAP;
                    end
                    else if (pp_reg == 16'd0) begin
                        accel_reg <= 16'd0 - HALF_CAP;
                    end
                    else begin
                        accel_reg <= dd[15:0];
                    end
                end
                default: ;
            endcase
        end
        if (load_out) begin
            o_speed_reg  <= speed_reg;
            o_half_reg   <= half[14:0];
            o_rpm_reg    <= rpm;
            o_coarse_reg <= speed_reg[15:8];
            o_capped_reg <= (rpm > RPM_CAP) ? RPM_CAP : rpm;
            o_filt_reg   <= filt_reg;
            o_deriv_reg  <= deriv_reg;
            o_accel_reg  <= accel_reg;
            o_err_reg    <= n_reg == 4'd0 || n_reg > 4'd4;
        end
    end

    assign out_valid        = out_valid_reg;
    assign speed_eighth_rpm = o_speed_reg;
    assign speed_half_res   = o_half_reg;
    assign speed_rpm        = o_rpm_reg;
    assign speed_coarse     = o_coarse_reg;
    assign speed_capped     = o_capped_reg;
    assign speed_filtered   = o_filt_reg;
    assign speed_derivative = signed'(o_deriv_reg);
    assign engine_accel     = signed'(o_accel_reg);
    assign count_error      = o_err_reg;

    a_accept_launches: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> div_req.start)
        else $error("accepted request did not start the divider");

    a_done_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg != S_IDLE && state_reg != S_DONE))
        else $error("divider finished outside a division step");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(speed_eighth_rpm)
                                      && $stable(speed_filtered)))
        else $error("stalled result changed");

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import esp_pkg::*;

    typedef struct packed {
        logic [15:0]        speed;
        logic [14:0]        half;
        logic [12:0]        rpm;
        logic [7:0]         coarse;
        logic [12:0]        capped;
        logic [12:0]        filt;
        logic signed [7:0]  deriv;
        logic signed [15:0] accel;
        logic               err;
    } speed_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [3:0] cfg_data = 4'd0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [15:0] tdc_period = 16'd0;
    logic out_valid;
    logic out_stall = 1'b0;
    speed_result_t got;

    logic [15:0] period_queue[$];
    speed_result_t speed_expected[$];
    logic [3:0] model_cyl;
    logic [15:0] model_prev;
    logic [12:0] model_hist[3];
    bit in_taken = 1'b0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_cycles = 0;
    int errors = 0;
    int cycle_count = 0;
    int sent_count = 0;

    engine_speed_from_tdc_period u_top (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .tdc_period(tdc_period),
        .out_valid(out_valid), .out_stall(out_stall),
        .speed_eighth_rpm(got.speed), .speed_half_res(got.half), .speed_rpm(got.rpm),
        .speed_coarse(got.coarse), .speed_capped(got.capped),
        .speed_filtered(got.filt), .speed_derivative(got.deriv),
        .engine_accel(got.accel), .count_error(got.err)
    );

    always #1 clk = ~clk;

    function automatic logic [31:0] limit_diff(logic [31:0] a, logic [31:0] b,
                                               logic [31:0] pcap, logic [31:0] ncap);
        if (a >= b)
            return (a - b > pcap) ? pcap : a - b;
        return 32'd0 - ((b - a > ncap) ? ncap : b - a);
    endfunction

    function automatic speed_result_t compute_speed(logic [15:0] p);
        speed_result_t r;
        logic [31:0] n, s, rpm, sum, q, d, a;
        n = {28'd0, model_cyl};
        s = 0;
        if (p != 0 && n != 0)
            s = 32'd37500000 / ({16'd0, p} * n);
        if (s > 32'd65535)
            s = 32'd65535;
        rpm = s / 8;
        case (n)
            1: sum = rpm;
            2: sum = rpm + model_hist[0];
            3: sum = rpm + model_hist[0] + model_hist[1];
            default: sum = rpm + model_hist[0] + model_hist[1] + model_hist[2];
        endcase
        d = 0;
        a = 0;
        if (n != 0) begin
            if (p == 0)
                d = 127;
            else if (model_prev == 0)
                d = -32'sd128;
            else begin
                q = 32'd2861022949 / p / n;
                d = limit_diff(q / p, q / model_prev, 127, 128);
            end
            if (p < 171)
                a = 32000;
            else if (model_prev == 0)
                a = -32'sd32000;
            else begin
                q = (32'd2861022949 / p) * 256 / n;
                a = limit_diff(q / p, q / model_prev, 32000, 32000);
            end
        end
        r.speed = s[15:0];
        r.half = (s / 2 > 32000) ? 15'd32000 : s[15:1];
        r.rpm = rpm[12:0];
        r.coarse = s[15:8];
        r.capped = (rpm > 7500) ? 13'd7500 : rpm[12:0];
        r.filt = (n != 0) ? 13'(sum / n) : 13'd8191;
        r.deriv = d[7:0];
        r.accel = a[15:0];
        r.err = (n == 0 || n > 4);
        model_hist[2] = model_hist[1];
        model_hist[1] = model_hist[0];
        model_hist[0] = rpm[12:0];
        model_prev = p;
        return r;
    endfunction

    // Driver: the model runs at acceptance, so configuration order is preserved.
    always @(negedge clk) begin
        if (rst_n) begin
            if (!in_valid || in_taken) begin
                in_taken = 1'b0;
                if (period_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    tdc_period <= period_queue[0];
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if (in_valid && !in_stall) begin
            speed_expected.push_back(compute_speed(tdc_period));
            void'(period_queue.pop_front());
            sent_count++;
            in_taken = 1'b1;
        end
    end

    always @(negedge clk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk) begin
        cycle_count++;
        if (out_valid && !out_stall) begin
            if (speed_expected.size() == 0) begin
                $display("%0t: unexpected request result %p", $time, got);
                errors++;
            end
            else begin
                if (got !== speed_expected[0]) begin
                    $display("%0t: mismatch expected %p actual %p", $time,
                             speed_expected[0], got);
                    errors++;
                end
                void'(speed_expected.pop_front());
            end
        end
        if (cycle_count > 2000000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic drain;
        wait (period_queue.size() == 0 && speed_expected.size() == 0);
        @(negedge clk);
        wait (!in_valid || !in_stall);
        repeat (2) @(negedge clk);
        wait (speed_expected.size() == 0);
        repeat (10) @(negedge clk);
    endtask

    task automatic set_cylinders(logic [3:0] v);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data <= v;
        model_cyl = v;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [15:0] random_period();
        case ($urandom_range(5))
            0: return 16'($urandom_range(200));
            1: return 16'($urandom_range(2000));
            2: return 16'($urandom_range(30000, 171));
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [3:0] cyl_list[8] = '{4'd4, 4'd1, 4'd2, 4'd3, 4'd0, 4'd15, 4'd5, 4'd8};
        model_cyl = 4'd4;
        model_prev = 16'd0;
        model_hist = '{13'd0, 13'd0, 13'd0};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        period_queue = '{16'd0, 16'd1, 16'd170, 16'd171, 16'd65535, 16'd2, 16'd0,
                         16'd172, 16'd1000, 16'd1000, 16'd32768, 16'd1};
        drain();
        set_cylinders(4'd0);
        period_queue = '{16'd100, 16'd0, 16'd5000};
        drain();
        set_cylinders(4'd15);
        period_queue = '{16'd1, 16'd200, 16'd65535, 16'd0};
        drain();
        set_cylinders(4'd1);
        period_queue = '{16'd1, 16'd2, 16'd572, 16'd300};
        drain();

        // Long receiver hold while the sender keeps offering requests.
        hold_cycles = 1500;
        for (int i = 0; i < 6; i++)
            period_queue.push_back(random_period());
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 84 : 0;
            recv_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 7 : 0;
            for (int k = 0; k < 8; k++) begin
                set_cylinders((k < 4) ? cyl_list[k] : 4'($urandom_range(15)));
                if (k == 3)
                    set_cylinders(cyl_list[4 + phase]);
                for (int i = 0; i < 48; i++)
                    period_queue.push_back(random_period());
                drain();
            end
        end

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
